// File: hw/rtl/bmf_pkg.sv
// Shared constants and types for the 3x3 box mean filter.
// Used by bmf_line_buf and box_mean_filter_3x3_unit; no dependencies.
`timescale 1ns / 1ps

package bmf_pkg;

  // Longest supported row, in pixels.
  localparam int unsigned MaxWidth = 2048;

  localparam int unsigned PixW = 8;
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = 12;
  localparam int unsigned CfgW = 12;

  // One column of three pixels sums to at most 765, a full window to 2295.
  localparam int unsigned ColSumW = PixW + 2;
  localparam int unsigned SumW = ColSumW + 2;

  // Division by 9 as a multiply by ceil(2^16 / 9) and a shift; exact for
  // every sum below 32768.
  localparam int unsigned DivShift = 16;
  localparam int unsigned DivMulW = 13;
  localparam logic [DivMulW-1:0] DivMul = DivMulW'(7282);
  localparam int unsigned ProdW = SumW + DivMulW;

  localparam logic [CfgW-1:0] FrameWidthReset = CfgW'(640);
  localparam logic [CfgW-1:0] FrameHeightReset = CfgW'(480);

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  // Write request for both line stores at one column.
  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
    logic [PixW-1:0] above;
    logic [PixW-1:0] two_above;
  } lb_wr_t;

endpackage

// File: hw/rtl/bmf_line_buf.sv
// Two line stores (previous row and the row before it) with registered reads.
// Depends on bmf_pkg for widths and the write request struct.
`timescale 1ns / 1ps

module bmf_line_buf (
  input  logic                      clk_i,
  input  bmf_pkg::lb_wr_t           wr_i,
  input  logic [bmf_pkg::ColW-1:0]  rd_addr_i,
  output logic [bmf_pkg::PixW-1:0]  rd_above_o,
  output logic [bmf_pkg::PixW-1:0]  rd_two_above_o
);

  logic [bmf_pkg::PixW-1:0] above_mem [bmf_pkg::MaxWidth];
  logic [bmf_pkg::PixW-1:0] two_above_mem [bmf_pkg::MaxWidth];
  logic [bmf_pkg::PixW-1:0] rd_above_q;
  logic [bmf_pkg::PixW-1:0] rd_two_above_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      above_mem[wr_i.addr] <= wr_i.above;
      two_above_mem[wr_i.addr] <= wr_i.two_above;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_above_q <= above_mem[rd_addr_i];
    rd_two_above_q <= two_above_mem[rd_addr_i];
  end

  assign rd_above_o = rd_above_q;
  assign rd_two_above_o = rd_two_above_q;

endmodule

// File: hw/rtl/box_mean_filter_3x3_unit.sv
// Streaming 3x3 box mean filter over 8-bit grey frames in raster order.
// A pixel is registered in stage 1 and its result in stage 2, which drives the output
// and holds each result until the output takes it.
// Throughput: one pixel per cycle unless stalled; the output carries one transaction a
// cycle, so a pixel with an interior and a border result holds it for both in turn.
// Reset: asynchronous, active low; registers return to 640 x 480, counters to zero.
`timescale 1ns / 1ps

module box_mean_filter_3x3_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [bmf_pkg::CfgW-1:0]  cfg_data_i,
  // Pixel input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bmf_pkg::PixW-1:0]  pixel_in_i,
  // Result output channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bmf_pkg::RowW-1:0]  out_row_o,
  output logic [bmf_pkg::ColW-1:0]  out_col_o,
  output logic [bmf_pkg::PixW-1:0]  out_value_o,
  output logic                      is_interior_o,
  output logic                      last_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write restarts the frame at row 0, column 0.
  // ---------------------------------------------------------------------------
  logic [bmf_pkg::CfgW-1:0] frame_width_q, frame_width_d;
  logic [bmf_pkg::CfgW-1:0] frame_height_q, frame_height_d;
  logic                     cfg_hit;

  always_comb begin
    frame_width_d = frame_width_q;
    frame_height_d = frame_height_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (bmf_pkg::cfg_reg_e'(cfg_idx_i))
        bmf_pkg::CfgFrameWidth: begin
          frame_width_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        bmf_pkg::CfgFrameHeight: begin
          frame_height_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= bmf_pkg::FrameWidthReset;
      frame_height_q <= bmf_pkg::FrameHeightReset;
    end else begin
      frame_width_q <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // A width of zero acts as one, a width above the line store depth as the
  // full depth. A height of zero acts as one.
  logic [bmf_pkg::CfgW-1:0] width_eff;
  logic [bmf_pkg::CfgW-1:0] height_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = bmf_pkg::CfgW'(1);
    end else if (frame_width_q > bmf_pkg::CfgW'(bmf_pkg::MaxWidth)) begin
      width_eff = bmf_pkg::CfgW'(bmf_pkg::MaxWidth);
    end else begin
      width_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      height_eff = bmf_pkg::CfgW'(1);
    end else begin
      height_eff = frame_height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds an accepted pixel with its window sum; stage 2
  // holds the finished item and presents its one or two results in turn.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;
  logic in_acc, out_acc;

  assign in_stall_o = !s1_ready;
  assign in_acc = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Position counters of the next pixel.
  // ---------------------------------------------------------------------------
  logic [bmf_pkg::ColW-1:0] col_cnt_q, col_cnt_d;
  logic [bmf_pkg::RowW-1:0] row_cnt_q, row_cnt_d;
  logic [bmf_pkg::CfgW-1:0] col_plus1;
  logic [bmf_pkg::RowW:0]   row_plus1;
  logic                     col_wrap, row_wrap;

  assign col_plus1 = bmf_pkg::CfgW'(col_cnt_q) + bmf_pkg::CfgW'(1);
  assign row_plus1 = {1'b0, row_cnt_q} + (bmf_pkg::RowW+1)'(1);
  assign col_wrap = col_plus1 >= width_eff;
  assign row_wrap = row_plus1 >= {1'b0, height_eff};

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (cfg_hit) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_cnt_d = '0;
        row_cnt_d = row_wrap ? '0 : row_plus1[bmf_pkg::RowW-1:0];
      end else begin
        col_cnt_d = col_plus1[bmf_pkg::ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The read address is the next pixel's column, so the stored
  // pixels above that column sit in the read registers when the pixel comes.
  // A column is written once per row, so with three or more columns the
  // entry read was written at least two transactions earlier. Narrower frames
  // never use the read data.
  // ---------------------------------------------------------------------------
  logic [bmf_pkg::PixW-1:0] px_above;
  logic [bmf_pkg::PixW-1:0] px_two_above;
  bmf_pkg::lb_wr_t          lb_wr;

  always_comb begin
    lb_wr.en = in_acc;
    lb_wr.addr = col_cnt_q;
    lb_wr.above = pixel_in_i;
    lb_wr.two_above = px_above;
  end

  bmf_line_buf u_line_buf (
    .clk_i          (clk_i),
    .wr_i           (lb_wr),
    .rd_addr_i      (col_cnt_d),
    .rd_above_o     (px_above),
    .rd_two_above_o (px_two_above)
  );

  // ---------------------------------------------------------------------------
  // Window. Only the sums of the two previous columns are kept; together with
  // the current column they give the 3x3 sum of original pixels.
  // ---------------------------------------------------------------------------
  logic [bmf_pkg::ColSumW-1:0] col_sum;
  logic [bmf_pkg::ColSumW-1:0] hist1_q, hist2_q;
  logic [bmf_pkg::SumW-1:0]    win_sum;
  logic                        pix_interior, pix_border;

  assign col_sum = bmf_pkg::ColSumW'(pixel_in_i) + bmf_pkg::ColSumW'(px_above)
                 + bmf_pkg::ColSumW'(px_two_above);
  assign win_sum = bmf_pkg::SumW'(col_sum) + bmf_pkg::SumW'(hist1_q)
                 + bmf_pkg::SumW'(hist2_q);

  // An interior result for the pixel up and to the left is due from row 2 and
  // column 2 on. The pixel itself passes through if it lies on the frame edge.
  assign pix_interior = (row_cnt_q[bmf_pkg::RowW-1:1] != '0)
                     && (col_cnt_q[bmf_pkg::ColW-1:1] != '0);
  assign pix_border = (row_cnt_q == '0) || row_wrap || (col_cnt_q == '0) || col_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist1_q <= '0;
      hist2_q <= '0;
    end else if (in_acc) begin
      hist1_q <= col_sum;
      hist2_q <= hist1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1. A pixel that causes no result leaves no entry.
  // ---------------------------------------------------------------------------
  logic [bmf_pkg::SumW-1:0] s1_sum_q;
  logic [bmf_pkg::PixW-1:0] s1_pix_q;
  logic [bmf_pkg::RowW-1:0] s1_row_q;
  logic [bmf_pkg::ColW-1:0] s1_col_q;
  logic                     s1_int_q, s1_bord_q;

  assign s1_ready = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_acc && (pix_interior || pix_border);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_acc) begin
      s1_sum_q <= win_sum;
      s1_pix_q <= pixel_in_i;
      s1_row_q <= row_cnt_q;
      s1_col_q <= col_cnt_q;
      s1_int_q <= pix_interior;
      s1_bord_q <= pix_border;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2. The mean is the window sum times the reciprocal of 9.
  // ---------------------------------------------------------------------------
  logic [bmf_pkg::ProdW-1:0] mean_prod;
  logic [bmf_pkg::PixW-1:0]  s2_mean_q;
  logic [bmf_pkg::PixW-1:0]  s2_pix_q;
  logic [bmf_pkg::RowW-1:0]  s2_row_q;
  logic [bmf_pkg::ColW-1:0]  s2_col_q;
  logic                      s2_int_q, s2_bord_q;
  logic                      s2_phase_q;
  logic                      show_int;

  assign mean_prod = bmf_pkg::ProdW'(s1_sum_q) * bmf_pkg::ProdW'(bmf_pkg::DivMul);

  // The interior result goes first; the border result follows in phase one.
  assign show_int = s2_int_q && !s2_phase_q;

  assign out_valid_o = s2_valid_q;
  assign out_row_o = show_int ? s2_row_q - bmf_pkg::RowW'(1) : s2_row_q;
  assign out_col_o = show_int ? s2_col_q - bmf_pkg::ColW'(1) : s2_col_q;
  assign out_value_o = show_int ? s2_mean_q : s2_pix_q;
  assign is_interior_o = show_int;
  assign last_o = show_int ? !s2_bord_q : 1'b1;

  assign out_acc = out_valid_o && !out_stall_i;
  assign s2_ready = !s2_valid_q || (out_acc && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_phase_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
      s2_phase_q <= 1'b0;
    end else if (out_acc) begin
      s2_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_mean_q <= mean_prod[bmf_pkg::DivShift +: bmf_pkg::PixW];
      s2_pix_q <= s1_pix_q;
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
      s2_int_q <= s1_int_q;
      s2_bord_q <= s1_bord_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The counters always stay inside the effective frame.
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_cnt_q} < width_eff) && (row_cnt_q < height_eff))
    else $error("position counter outside the frame");

  // A pending item always has at least one result to give.
  a_s2_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_int_q || s2_bord_q))
    else $error("output stage holds an item without results");

  // The second phase is only reached by an item with two results.
  a_phase_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_phase_q |-> (s2_valid_q && s2_int_q && s2_bord_q))
    else $error("second result phase on a single-result item");

  // An interior result that is taken without being last is followed by the
  // border result of the same pixel.
  a_border_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && is_interior_o && !last_o) |=>
      (out_valid_o && !is_interior_o && last_o
       && (out_row_o == $past(out_row_o) + bmf_pkg::RowW'(1))))
    else $error("border result missing after interior result");

endmodule
